// ===== src/gsa_pkg.sv =====
// Shared types and codes for the generational slot allocator.
// No dependencies; every other file of the block but gsa_ram uses this package.
`default_nettype none
package gsa_pkg;

    // Table size; the 8-bit slot field of a handle fixes it.
    localparam int SLOTS = 256;

    typedef enum logic [2:0] {
        CMD_CREATE  = 3'd0,
        CMD_DESTROY = 3'd1,
        CMD_CHECK   = 3'd2,
        CMD_READ    = 3'd3,
        CMD_FIND    = 3'd4,
        CMD_BAD     = 3'd7
    } t_cmd;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DEAD = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    localparam int IN_BITS  = 80;
    localparam int OUT_BITS = 88;

    // One decoded command as it waits in the queue.
    typedef struct packed {
        t_cmd        cmd;
        logic [7:0]  slot;
        logic [15:0] generation;
        logic [31:0] owner_id;
        logic [15:0] node_number;
    } t_item;

    // Queue head as offered to the back end.
    typedef struct packed {
        logic  valid;
        t_item item;
    } t_queue;

endpackage
`default_nettype wire

// ===== src/gsa_ram.sv =====
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`default_nettype none
module gsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== src/gsa_front.sv =====
// Front end: unpacks input transfers, classifies the command code and
// holds up to two commands for the back end. Depends on gsa_pkg.
`default_nettype none
module gsa_front (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_tvalid,
    output logic                              o_tready,
    input  wire logic [gsa_pkg::IN_BITS-1:0]  i_tdata,
    output gsa_pkg::t_queue                   o_queue,
    input  wire logic                         i_pop
);
    gsa_pkg::t_item r_buf [2];
    logic           r_wptr, r_rptr;
    logic [1:0]     r_count;
    gsa_pkg::t_item w_item;
    logic           w_push;

    always_comb begin
        w_item.slot        = i_tdata[10:3];
        w_item.generation  = i_tdata[26:11];
        w_item.owner_id    = i_tdata[58:27];
        w_item.node_number = i_tdata[74:59];
        case (i_tdata[2:0])
            3'd0:    w_item.cmd = gsa_pkg::CMD_CREATE;
            3'd1:    w_item.cmd = gsa_pkg::CMD_DESTROY;
            3'd2:    w_item.cmd = gsa_pkg::CMD_CHECK;
            3'd3:    w_item.cmd = gsa_pkg::CMD_READ;
            3'd4:    w_item.cmd = gsa_pkg::CMD_FIND;
            default: w_item.cmd = gsa_pkg::CMD_BAD;
        endcase
    end

    assign o_tready      = (r_count != 2'd2);
    assign w_push        = i_tvalid && o_tready;
    assign o_queue.valid = (r_count != 2'd0);
    assign o_queue.item  = r_buf[r_rptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_buf[r_wptr] <= w_item;
        end
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (w_push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
            r_count <= r_count + 2'(w_push) - 2'(i_pop);
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n) i_pop |-> o_queue.valid)
        else $error("queue popped while empty");
endmodule
`default_nettype wire

// ===== src/gsa_back.sv =====
// Back end: executes one command at a time against the slot tables and
// holds the result in an output register. Depends on gsa_pkg and gsa_ram.
`default_nettype none
module gsa_back (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  gsa_pkg::t_queue                   i_queue,
    output logic                              o_pop,
    output logic                              o_tvalid,
    input  wire logic                         i_tready,
    output logic      [gsa_pkg::OUT_BITS-1:0] o_tdata
);
    localparam int IW = $clog2(gsa_pkg::SLOTS);
    localparam int CW = $clog2(gsa_pkg::SLOTS + 1);
    localparam int EW = 65;
    localparam logic [CW-1:0] END_MARK = CW'(gsa_pkg::SLOTS);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state         r_state, n_state;
    gsa_pkg::t_item r_item, n_item;
    logic [CW-1:0]  r_addr, n_addr;
    logic [CW-1:0]  r_head, n_head;
    logic [CW-1:0]  r_used, n_used;
    logic [CW-1:0]  r_live, n_live;
    logic           r_ovalid, n_ovalid;
    logic [1:0]     r_status, n_status;
    logic [7:0]     r_oslot, n_oslot;
    logic [15:0]    r_ogen, n_ogen;
    logic [31:0]    r_oown, n_oown;
    logic [15:0]    r_onode, n_onode;

    logic           w_ent_we, w_lnk_we;
    logic [IW-1:0]  w_waddr;
    logic [EW-1:0]  w_ent_wdata, w_ent_rdata;
    logic [CW-1:0]  w_lnk_rdata;
    logic           w_handle_ok, w_match;
    logic [CW-1:0]  w_id;
    logic [15:0]    w_gen;

    gsa_ram #(.WIDTH(EW), .DEPTH(gsa_pkg::SLOTS)) u_entry (
        .i_clk(i_clk), .i_we(w_ent_we), .i_waddr(w_waddr), .i_wdata(w_ent_wdata),
        .i_raddr(n_addr[IW-1:0]), .o_rdata(w_ent_rdata)
    );
    gsa_ram #(.WIDTH(CW), .DEPTH(gsa_pkg::SLOTS)) u_link (
        .i_clk(i_clk), .i_we(w_lnk_we), .i_waddr(w_waddr), .i_wdata(r_head),
        .i_raddr(n_addr[IW-1:0]), .o_rdata(w_lnk_rdata)
    );

    // Entry word: live bit, generation, owner id, node id.
    assign w_handle_ok = (32'(r_item.slot) < 32'(r_used)) && w_ent_rdata[64]
                         && (w_ent_rdata[63:48] == r_item.generation);
    assign w_match     = (r_addr < r_used) && w_ent_rdata[64]
                         && (w_ent_rdata[47:16] == r_item.owner_id)
                         && (w_ent_rdata[15:0] == r_item.node_number);

    always_comb begin
        n_state  = r_state;
        n_item   = r_item;
        n_addr   = r_addr;
        n_head   = r_head;
        n_used   = r_used;
        n_live   = r_live;
        n_ovalid = r_ovalid && !i_tready;
        n_status = r_status;
        n_oslot  = r_oslot;
        n_ogen   = r_ogen;
        n_oown   = r_oown;
        n_onode  = r_onode;
        o_pop    = 1'b0;
        w_ent_we = 1'b0;
        w_lnk_we = 1'b0;
        w_waddr  = r_addr[IW-1:0];
        w_ent_wdata = '0;
        w_id     = r_used;
        w_gen    = 16'd0;
        case (r_state)
            S_IDLE: begin
                if (i_queue.valid) begin
                    o_pop   = 1'b1;
                    n_item  = i_queue.item;
                    n_state = S_EXEC;
                    case (i_queue.item.cmd)
                        gsa_pkg::CMD_CREATE: n_addr = (r_head < END_MARK) ? r_head : r_used;
                        gsa_pkg::CMD_FIND:   n_addr = '0;
                        default:             n_addr = CW'(i_queue.item.slot);
                    endcase
                end
            end
            S_EXEC: begin
                if (!r_ovalid || i_tready) begin
                    n_state  = S_IDLE;
                    n_ovalid = 1'b1;
                    n_status = gsa_pkg::ST_DEAD;
                    n_oslot  = 8'd0;
                    n_ogen   = 16'd0;
                    n_oown   = 32'd0;
                    n_onode  = 16'd0;
                    case (r_item.cmd)
                        gsa_pkg::CMD_CREATE: begin
                            if (r_head < END_MARK) begin
                                w_id   = r_head;
                                w_gen  = w_ent_rdata[63:48];
                                n_head = w_lnk_rdata;
                            end else if (r_used < END_MARK) begin
                                n_used = r_used + 1'b1;
                            end
                            if ((r_head < END_MARK) || (r_used < END_MARK)) begin
                                w_ent_we    = 1'b1;
                                w_waddr     = w_id[IW-1:0];
                                w_ent_wdata = {1'b1, w_gen, r_item.owner_id,
                                               r_item.node_number};
                                n_live      = r_live + 1'b1;
                                n_status    = gsa_pkg::ST_OK;
                                n_oslot     = 8'(w_id);
                                n_ogen      = w_gen;
                            end else begin
                                n_status = gsa_pkg::ST_FULL;
                            end
                        end
                        gsa_pkg::CMD_DESTROY: begin
                            if (w_handle_ok) begin
                                w_ent_we    = 1'b1;
                                w_lnk_we    = 1'b1;
                                w_ent_wdata = {1'b0, w_ent_rdata[63:48] + 16'd1, 48'd0};
                                n_head      = r_addr;
                                n_live      = r_live - 1'b1;
                                n_status    = gsa_pkg::ST_OK;
                            end
                        end
                        gsa_pkg::CMD_CHECK: begin
                            if (w_handle_ok) begin
                                n_status = gsa_pkg::ST_OK;
                            end
                        end
                        gsa_pkg::CMD_READ: begin
                            if (w_handle_ok) begin
                                n_status = gsa_pkg::ST_OK;
                                n_oown   = w_ent_rdata[47:16];
                                n_onode  = w_ent_rdata[15:0];
                            end
                        end
                        gsa_pkg::CMD_FIND: begin
                            if (w_match) begin
                                n_status = gsa_pkg::ST_OK;
                                n_oslot  = 8'(r_addr);
                                n_ogen   = w_ent_rdata[63:48];
                            end else if (r_addr < r_used) begin
                                // Keep scanning; no result yet.
                                n_state  = S_EXEC;
                                n_ovalid = r_ovalid && !i_tready;
                                n_addr   = r_addr + 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_tvalid = r_ovalid;
    assign o_tdata  = {5'd0, 9'(r_live), r_onode, r_oown, r_ogen, r_oslot, r_status};

    always_ff @(posedge i_clk) begin
        r_item   <= n_item;
        r_addr   <= n_addr;
        r_status <= n_status;
        r_oslot  <= n_oslot;
        r_ogen   <= n_ogen;
        r_oown   <= n_oown;
        r_onode  <= n_onode;
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_head   <= END_MARK;
            r_used   <= '0;
            r_live   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_used   <= n_used;
            r_live   <= n_live;
            r_ovalid <= n_ovalid;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_live <= r_used)
        else $error("live count exceeds used slots");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_head == END_MARK) || (r_head < r_used))
        else $error("free list head points at a never used slot");
    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_used <= END_MARK)
        else $error("used slot count beyond table size");
endmodule
`default_nettype wire

// ===== src/generational_slot_allocator.sv =====
// Top level of the generational slot allocator: input queue front end plus
// executing back end. Depends on gsa_pkg, gsa_front, gsa_back, gsa_ram.
//
// Usage: each transfer on the s_axis channel carries one command (create,
// destroy, check, read or find). Every command produces exactly one result
// transfer on the m_axis channel, in command order.
// Create, destroy, check and read pass through two back-end states: one to
// read the slot's entry from the table RAM, one to update it and register
// the result. Find walks the used slots from slot 0 upward, one slot per
// cycle unless the previous result still waits on m_axis_tready.
// A two-entry queue sits between the front and the back end, so new
// commands are taken while the back end works or its result waits.
// The result register holds its transfer while m_axis_tready is low; the
// back end stalls then and the queue fills, dropping s_axis_tready.
// Reset (i_rst_n low at a clock edge) empties the queue, drops the result,
// empties the free list and clears the live and used-slot counts; the
// table RAMs need no clearing because only ever-used slots are read.
`default_nettype none
module generational_slot_allocator (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // command[2:0], slot[10:3], generation[26:11], owner_id[58:27],
    // node_number[74:59], zero fill [79:75]
    input  wire logic [79:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // status[1:0], out_slot[9:2], out_generation[25:10], out_owner_id[57:26],
    // out_node_number[73:58], live_total[82:74], zero fill [87:83]
    output logic      [87:0] m_axis_tdata
);
    gsa_pkg::t_queue w_queue;
    logic            w_pop;

    gsa_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tvalid (s_axis_tvalid),
        .o_tready (s_axis_tready),
        .i_tdata  (s_axis_tdata),
        .o_queue  (w_queue),
        .i_pop    (w_pop)
    );

    gsa_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_queue  (w_queue),
        .o_pop    (w_pop),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata)
    );
endmodule
`default_nettype wire

// ===== bench/generational_slot_allocator_tb.sv =====
// Self-checking bench for the generational slot allocator: drives command
// transfers, predicts each result with a behavioral slot table, checks all.
// Depends on gsa_pkg and the generational_slot_allocator RTL.
`timescale 1ns / 100ps
`default_nettype none
module generational_slot_allocator_tb;

    localparam int NSLOTS = 256;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int HOLD_LEN = 300;

    // Packed from the highest field down, so status lands in the low bits.
    typedef struct packed {
        logic [8:0]  live_total;
        logic [15:0] node_number;
        logic [31:0] owner_id;
        logic [15:0] generation;
        logic [7:0]  slot;
        logic [1:0]  status;
    } t_answer;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [87:0] m_axis_tdata;

    generational_slot_allocator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Shadow copy of the slot table, updated as each command is accepted.
    logic [8:0]  link_of [NSLOTS];
    logic [15:0] gen_of [NSLOTS];
    logic        live_of [NSLOTS];
    logic [31:0] owner_of [NSLOTS];
    logic [15:0] node_of [NSLOTS];
    int          head_free;
    int          used_slots;
    int          live_cnt;

    logic [79:0] cmd_queue [$];
    t_answer     answers_due [$];
    int          errors = 0;
    int          cycles = 0;
    int          results_seen = 0;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          hold_requests = 0;
    int          hold_served;
    int          hold_cycles;

    // Handles the bench has handed out and not yet destroyed.
    logic [7:0]  live_slots [$];
    logic [15:0] live_gens [$];
    logic [31:0] live_owners [$];
    logic [15:0] live_nodes [$];

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic bit handle_ok(int s, logic [15:0] g);
        return s < used_slots && live_of[s] && gen_of[s] == g;
    endfunction

    // Applies one command to the shadow table and returns its answer.
    function automatic t_answer allocate_step(logic [79:0] word);
        t_answer     a;
        logic [2:0]  op;
        int          s;
        int          id;
        logic [15:0] g;
        logic [31:0] ow;
        logic [15:0] nd;
        op = word[2:0];
        s  = int'(word[10:3]);
        g  = word[26:11];
        ow = word[58:27];
        nd = word[74:59];
        a = '0;
        a.status = gsa_pkg::ST_DEAD;
        case (op)
            gsa_pkg::CMD_CREATE: begin
                id = -1;
                if (head_free < NSLOTS) begin
                    id = head_free;
                    head_free = int'(link_of[id]);
                end else if (used_slots < NSLOTS) begin
                    id = used_slots;
                    used_slots++;
                    gen_of[id] = '0;
                end else begin
                    a.status = gsa_pkg::ST_FULL;
                end
                if (id >= 0) begin
                    owner_of[id] = ow;
                    node_of[id] = nd;
                    live_of[id] = 1'b1;
                    live_cnt++;
                    a.status = gsa_pkg::ST_OK;
                    a.slot = 8'(id);
                    a.generation = gen_of[id];
                end
            end
            gsa_pkg::CMD_DESTROY: begin
                if (handle_ok(s, g)) begin
                    gen_of[s] = gen_of[s] + 16'd1;
                    live_of[s] = 1'b0;
                    owner_of[s] = '0;
                    node_of[s] = '0;
                    link_of[s] = 9'(head_free);
                    head_free = s;
                    live_cnt--;
                    a.status = gsa_pkg::ST_OK;
                end
            end
            gsa_pkg::CMD_CHECK: if (handle_ok(s, g)) a.status = gsa_pkg::ST_OK;
            gsa_pkg::CMD_READ: begin
                if (handle_ok(s, g)) begin
                    a.status = gsa_pkg::ST_OK;
                    a.owner_id = owner_of[s];
                    a.node_number = node_of[s];
                end
            end
            gsa_pkg::CMD_FIND: begin
                for (int i = 0; i < used_slots; i++) begin
                    if (live_of[i] && owner_of[i] == ow && node_of[i] == nd) begin
                        a.status = gsa_pkg::ST_OK;
                        a.slot = 8'(i);
                        a.generation = gen_of[i];
                        break;
                    end
                end
            end
            default: ;
        endcase
        a.live_total = 9'(live_cnt);
        return a;
    endfunction

    function automatic logic [79:0] pack_cmd(logic [2:0] op, logic [7:0] s,
                                             logic [15:0] g, logic [31:0] ow,
                                             logic [15:0] nd);
        return {5'd0, nd, ow, g, s, op};
    endfunction

    task automatic enqueue_cmd(logic [79:0] w);
        cmd_queue.insert(cmd_queue.size(), w);
    endtask

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        errors++;
        $display("mismatch at result %0d: %s got %0h expected %0h",
                 results_seen, what, got, want);
    endtask

    // Keeps the list of live handles that steers stimulus toward valid ones.
    task automatic track_handle(logic [79:0] w, t_answer a);
        if (w[2:0] == gsa_pkg::CMD_CREATE && a.status == gsa_pkg::ST_OK) begin
            live_slots.insert(live_slots.size(), a.slot);
            live_gens.insert(live_gens.size(), a.generation);
            live_owners.insert(live_owners.size(), w[58:27]);
            live_nodes.insert(live_nodes.size(), w[74:59]);
        end else if (w[2:0] == gsa_pkg::CMD_DESTROY && a.status == gsa_pkg::ST_OK) begin
            foreach (live_slots[j]) begin
                if (live_slots[j] == w[10:3]) begin
                    live_slots.delete(j);
                    live_gens.delete(j);
                    live_owners.delete(j);
                    live_nodes.delete(j);
                    break;
                end
            end
        end
    endtask

    // Driver: offers the queue head; accepted commands update the shadow table.
    always @(posedge i_clk) begin
        t_answer a;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            head_free = NSLOTS;
            used_slots = 0;
            live_cnt = 0;
            foreach (live_of[i]) live_of[i] = 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                a = allocate_step(s_axis_tdata);
                answers_due.insert(answers_due.size(), a);
                track_handle(s_axis_tdata, a);
                void'(cmd_queue.pop_front());
            end
            if (s_axis_tvalid && !s_axis_tready) begin
                // Keep offering the same transfer until it is taken.
            end else if (cmd_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= cmd_queue[0];
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off, counted down here once the stimulus asks for it.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_cycles <= 0;
            hold_served <= 0;
        end else if (hold_served != hold_requests) begin
            hold_cycles <= HOLD_LEN;
            hold_served <= hold_requests;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
        end
    end

    // Monitor: checks each result transfer and randomizes tready.
    always @(posedge i_clk) begin
        t_answer got;
        t_answer want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[82:0];
                results_seen++;
                if (answers_due.size() == 0) begin
                    report_mismatch("unexpected transfer", 64'(got), 64'd0);
                end else begin
                    want = answers_due.pop_front();
                    if (got.status != want.status)
                        report_mismatch("status", 64'(got.status), 64'(want.status));
                    if (got.slot != want.slot)
                        report_mismatch("slot", 64'(got.slot), 64'(want.slot));
                    if (got.generation != want.generation)
                        report_mismatch("generation", 64'(got.generation),
                                        64'(want.generation));
                    if (got.owner_id != want.owner_id)
                        report_mismatch("owner", 64'(got.owner_id), 64'(want.owner_id));
                    if (got.node_number != want.node_number)
                        report_mismatch("node", 64'(got.node_number),
                                        64'(want.node_number));
                    if (got.live_total != want.live_total)
                        report_mismatch("live_total", 64'(got.live_total),
                                        64'(want.live_total));
                end
            end
            if (hold_cycles > 0) begin
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Cycle counter with a hard limit.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout with %0d results outstanding", answers_due.size());
            $display("** generational_slot_allocator: FAILED **");
            $finish;
        end
    end

    // Pushes a random command, biased toward handles that are actually live.
    task automatic queue_random_cmd();
        int          pick;
        int          k;
        logic [31:0] ow;
        logic [15:0] nd;
        pick = $urandom_range(99);
        ow = ($urandom_range(3) == 0) ? $urandom() : $urandom_range(3);
        nd = 16'(($urandom_range(3) == 0) ? $urandom() : $urandom_range(3));
        k = live_slots.size() ? $urandom_range(live_slots.size() - 1) : 0;
        if (pick < 34) begin
            enqueue_cmd(pack_cmd(gsa_pkg::CMD_CREATE, 8'($urandom()), 16'($urandom()),
                                 ow, nd));
        end else if (live_slots.size() && pick < 90) begin
            case ($urandom_range(3))
                0: enqueue_cmd(pack_cmd(gsa_pkg::CMD_DESTROY, live_slots[k],
                                        live_gens[k], $urandom(), 16'($urandom())));
                1: enqueue_cmd(pack_cmd(gsa_pkg::CMD_CHECK, live_slots[k],
                                        live_gens[k], $urandom(), 16'($urandom())));
                2: enqueue_cmd(pack_cmd(gsa_pkg::CMD_READ, live_slots[k],
                                        live_gens[k], $urandom(), 16'($urandom())));
                default: enqueue_cmd(pack_cmd(gsa_pkg::CMD_FIND, 8'($urandom()),
                                              16'($urandom()), live_owners[k],
                                              live_nodes[k]));
            endcase
        end else begin
            // Noise: stale or random handles, random finds, unknown codes.
            enqueue_cmd(pack_cmd(3'($urandom_range(1, 7)), 8'($urandom()),
                                 16'($urandom_range(1) ? $urandom() : $urandom_range(2)),
                                 ow, nd));
        end
    endtask

    task automatic wait_drained();
        while (cmd_queue.size() || s_axis_tvalid || answers_due.size())
            @(posedge i_clk);
    endtask

    initial begin
        i_rst_n = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: empty table, extremes, every command, dead handles.
        enqueue_cmd(pack_cmd(gsa_pkg::CMD_CHECK, 8'd0, 16'd0, '0, '0));
        enqueue_cmd(pack_cmd(gsa_pkg::CMD_FIND, 8'd0, 16'd0, '0, '0));
        enqueue_cmd(pack_cmd(gsa_pkg::CMD_CREATE, 8'hff, 16'hffff, 32'hffffffff, 16'hffff));
        enqueue_cmd(pack_cmd(gsa_pkg::CMD_CREATE, 8'd0, 16'd0, 32'd0, 16'd0));
        enqueue_cmd(pack_cmd(gsa_pkg::CMD_READ, 8'd0, 16'd0, '0, '0));
        enqueue_cmd(pack_cmd(gsa_pkg::CMD_READ, 8'd0, 16'd1, '0, '0));
        enqueue_cmd(pack_cmd(gsa_pkg::CMD_CHECK, 8'hff, 16'd0, '0, '0));
        enqueue_cmd(pack_cmd(gsa_pkg::CMD_FIND, 8'd0, 16'd0, 32'hffffffff, 16'hffff));
        enqueue_cmd(pack_cmd(gsa_pkg::CMD_FIND, 8'd0, 16'd0, 32'hffffffff, 16'hfffe));
        enqueue_cmd(pack_cmd(gsa_pkg::CMD_DESTROY, 8'd0, 16'd0, '0, '0));
        enqueue_cmd(pack_cmd(gsa_pkg::CMD_DESTROY, 8'd0, 16'd0, '0, '0));
        enqueue_cmd(pack_cmd(gsa_pkg::CMD_READ, 8'd0, 16'd0, '0, '0));
        enqueue_cmd(pack_cmd(gsa_pkg::CMD_CREATE, 8'd0, 16'd0, 32'h5a5a5a5a, 16'ha5a5));
        enqueue_cmd(pack_cmd(gsa_pkg::CMD_CHECK, 8'd0, 16'd1, '0, '0));
        enqueue_cmd(pack_cmd(gsa_pkg::CMD_BAD, 8'hff, 16'hffff, 32'hffffffff, 16'hffff));
        enqueue_cmd(pack_cmd(3'd5, 8'd1, 16'd0, '0, '0));
        enqueue_cmd(pack_cmd(3'd6, 8'd1, 16'd0, '0, '0));
        enqueue_cmd(pack_cmd(gsa_pkg::CMD_DESTROY, 8'd1, 16'd0, '0, '0));
        wait_drained();

        // Fill the table to the brim, then a full-table create, with a long
        // receiver hold-off so the input queue backs up.
        hold_requests = hold_requests + 1;
        for (int i = 0; i < NSLOTS; i++)
            enqueue_cmd(pack_cmd(gsa_pkg::CMD_CREATE, '0, '0, 32'($urandom_range(7)),
                                 16'($urandom())));
        enqueue_cmd(pack_cmd(gsa_pkg::CMD_CREATE, '0, '0, 32'd1, 16'd1));
        enqueue_cmd(pack_cmd(gsa_pkg::CMD_FIND, '0, '0, 32'hdeadbeef, 16'd7));
        wait_drained();

        // Random phases with different idling mixes.
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 24 : 49) : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 24 : 49) : 0;
            for (int n = 0; n < 320; n++) begin
                while (cmd_queue.size() > 4) @(posedge i_clk);
                queue_random_cmd();
            end
            wait_drained();
        end
        repeat (40) @(posedge i_clk);

        $display("run covered %0d results: create, destroy, check, read, find,", results_seen);
        $display("unknown codes, a full table, dead handles and back-pressure phases");
        if (errors == 0 && answers_due.size() == 0) begin
            $display("** generational_slot_allocator: PASSED **");
        end else begin
            $display("** generational_slot_allocator: FAILED **");
        end
        $finish;
    end
endmodule
`default_nettype wire
